/* rtl/core/hds2d_pkg.sv */
// package for the 2d heat diffusion stencil block
// holds item codes, boundary modes and phases, register indexes and parameter defaults; no dependencies
`timescale 1ns / 1ps

package hds2d_pkg;

  localparam int GRID_SIDE_DEF  = 64;
  localparam int VALUE_BITS_DEF = 32;

  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_RUN   = 2'd2;

  localparam logic [1:0] MODE_FIXED    = 2'd0;
  localparam logic [1:0] MODE_OPEN     = 2'd1;
  localparam logic [1:0] MODE_PERIODIC = 2'd2;

  localparam logic [2:0] REG_COEFF_X   = 3'd0;
  localparam logic [2:0] REG_COEFF_Y   = 3'd1;
  localparam logic [2:0] REG_BND_MODE  = 3'd2;
  localparam logic [2:0] REG_EDGE_TEMP = 3'd3;
  localparam logic [2:0] REG_STEPS     = 3'd4;

  localparam logic [1:0] BND_TOP  = 2'd0;
  localparam logic [1:0] BND_SIDE = 2'd1;
  localparam logic [1:0] BND_BOT  = 2'd2;

endpackage

/* rtl/core/heat_diffusion_stencil_2d.sv */
// 2d heat diffusion stencil: two grid memories, cell load/read and ftcs time steps
// depends on hds2d_pkg
//
//  channel  | direction | handshake              | payload
//  in       | input     | in_valid_i / in_stall_o | action_i, row_i, col_i, cell_value_i
//  out      | output    | out_valid_o / out_stall_i | read_value_o, run_done_o
//  cfg      | input     | cfg_we_i               | cfg_index_i, cfg_data_i
//
// a write item is stored in the cycle it is accepted; a read item holds the input off while
// its result passes the memory read register and then the output register
// during a run every interior cell needs five reads through the single memory read port,
// every boundary cell a read and a write; in_stall_o stays high for the whole run and
// while a result waits stalled
// reset clears control and registers only; grid contents are undefined until written
`timescale 1ns / 1ps

module heat_diffusion_stencil_2d
  import hds2d_pkg::*;
#(
  parameter int GRID_SIDE  = GRID_SIDE_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         action_i,
  input  logic [5:0]         row_i,
  input  logic [5:0]         col_i,
  input  logic signed [31:0] cell_value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] read_value_o,
  output logic               run_done_o,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  localparam int S     = GRID_SIDE;
  localparam int VB    = VALUE_BITS;
  localparam int CELLS = S * S;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(S);
  localparam int DW    = VB + 3;
  localparam int PW    = DW + 17;
  localparam int WW    = VB + 24;

  localparam logic signed [WW-1:0] VMAX = {{(WW-VB+1){1'b0}}, {(VB-1){1'b1}}};
  localparam logic signed [WW-1:0] VMIN = ~VMAX;
  localparam logic signed [WW-1:0] RMAX = {{(WW-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [WW-1:0] RMIN = ~RMAX;

  localparam logic [CW-1:0] LAST  = CW'(S - 1);
  localparam logic [CW-1:0] PENUL = CW'(S - 2);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_BRD  = 3'd1;
  localparam logic [2:0] ST_BWR  = 3'd2;
  localparam logic [2:0] ST_CELL = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  function automatic logic [AW-1:0] cell_addr(input logic [8:0] r, input logic [8:0] c);
    logic [17:0] full;
    full = 18'(r) * 18'(S) + 18'(c);
    cell_addr = full[AW-1:0];
  endfunction

  function automatic logic [VB-1:0] sat_v(input logic signed [WW-1:0] x);
    if (x > VMAX) sat_v = VMAX[VB-1:0];
    else if (x < VMIN) sat_v = VMIN[VB-1:0];
    else sat_v = x[VB-1:0];
  endfunction

  function automatic logic [31:0] sat_r(input logic signed [WW-1:0] x);
    if (x > RMAX) sat_r = RMAX[31:0];
    else if (x < RMIN) sat_r = RMIN[31:0];
    else sat_r = x[31:0];
  endfunction

  // configuration
  logic [15:0]        coeff_x_q, coeff_y_q, steps_cfg_q;
  logic [1:0]         mode_q;
  logic signed [31:0] edge_q;

  // grid memories
  logic [VB-1:0] mem0 [CELLS];
  logic [VB-1:0] mem1 [CELLS];
  logic [VB-1:0] rd0_q, rd1_q;
  logic          rd_bank_q, rd_bank;
  logic [AW-1:0] ra, wa;
  logic          we, wbank;
  logic [VB-1:0] wd;
  logic signed [VB-1:0] rdata;

  // control
  logic [2:0]    state_q, state_d;
  logic          cur_q, cur_d, bank_b_q, bank_b_d, in_step_q, in_step_d;
  logic [15:0]   steps_q, steps_d;
  logic [1:0]    bph_q, bph_d;
  logic [CW-1:0] bi_q, bi_d, r_q, r_d, c_q, c_d;
  logic          side_q, side_d;
  logic [3:0]    ph_q, ph_d;
  logic          rd_pend_q, rd_zero_q;
  logic          out_valid_q, out_done_q;
  logic [31:0]   out_val_q;

  // datapath registers
  logic signed [VB-1:0] mid_q, west_q, east_q, north_q, south_q;
  logic signed [DW-1:0] dx_q, dy_q;
  logic signed [PW-1:0] px_q, py_q;
  logic signed [PW-1:0] sx, sy;
  logic signed [WW-1:0] sum;

  logic          accept, in_range, fixed_mode, open_mode, bnd_last, out_free;
  logic [8:0]    row9, col9, bi9, r9, c9;
  logic [8:0]    dst_r, dst_c, src_r, src_c;
  logic [VB-1:0] edge_sat;

  assign rdata      = rd_bank_q ? rd1_q : rd0_q;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE) || rd_pend_q || !out_free;
  assign accept     = in_valid_i && !in_stall_o;
  assign row9       = 9'(row_i);
  assign col9       = 9'(col_i);
  assign in_range   = (row9 < 9'(S)) && (col9 < 9'(S));
  assign open_mode  = (mode_q == MODE_OPEN);
  assign fixed_mode = (mode_q != MODE_OPEN) && (mode_q != MODE_PERIODIC);
  assign edge_sat   = sat_v(WW'(edge_q));
  assign bi9        = 9'(bi_q);
  assign r9         = 9'(r_q);
  assign c9         = 9'(c_q);

  // boundary source and destination for the current boundary cell
  always_comb begin
    dst_r = 9'd0;
    dst_c = bi9;
    src_r = open_mode ? 9'd1 : 9'(S - 2);
    src_c = bi9;
    case (bph_q)
      BND_TOP: begin
        dst_r = 9'd0;
      end
      BND_SIDE: begin
        dst_r = bi9;
        src_r = bi9;
        if (!side_q) begin
          dst_c = 9'd0;
          src_c = open_mode ? 9'd1 : 9'(S - 2);
        end else begin
          dst_c = 9'(S - 1);
          src_c = open_mode ? 9'(S - 2) : 9'd1;
        end
      end
      default: begin
        dst_r = 9'(S - 1);
        src_r = open_mode ? 9'(S - 2) : 9'd1;
      end
    endcase
  end

  assign bnd_last = (bph_q == BND_BOT) && (bi_q == LAST);

  assign sx  = (px_q + PW'(32768)) >>> 16;
  assign sy  = (py_q + PW'(32768)) >>> 16;
  assign sum = WW'(mid_q) + WW'(sx) + WW'(sy);

  always_comb begin
    state_d   = state_q;
    cur_d     = cur_q;
    bank_b_d  = bank_b_q;
    in_step_d = in_step_q;
    steps_d   = steps_q;
    bph_d     = bph_q;
    bi_d      = bi_q;
    side_d    = side_q;
    r_d       = r_q;
    c_d       = c_q;
    ph_d      = ph_q;
    ra        = cell_addr(row9, col9);
    rd_bank   = cur_q;
    we        = 1'b0;
    wbank     = cur_q;
    wa        = cell_addr(row9, col9);
    wd        = sat_v(WW'(cell_value_i));
    case (state_q)
      ST_IDLE: begin
        if (accept && action_i == ACT_WRITE && in_range) begin
          we = 1'b1;
        end
        if (accept && action_i == ACT_RUN) begin
          state_d   = ST_BRD;
          bank_b_d  = cur_q;
          in_step_d = 1'b0;
          steps_d   = steps_cfg_q;
          bph_d     = BND_TOP;
          bi_d      = '0;
          side_d    = 1'b0;
        end
      end
      ST_BRD: begin
        ra      = cell_addr(src_r, src_c);
        rd_bank = bank_b_q;
        state_d = ST_BWR;
      end
      ST_BWR: begin
        we      = 1'b1;
        wbank   = bank_b_q;
        wa      = cell_addr(dst_r, dst_c);
        wd      = fixed_mode ? edge_sat : rdata;
        state_d = ST_BRD;
        case (bph_q)
          BND_TOP: begin
            if (bi_q == LAST) begin
              bph_d = BND_SIDE;
              bi_d  = '0;
            end else begin
              bi_d = bi_q + 1'b1;
            end
          end
          BND_SIDE: begin
            side_d = !side_q;
            if (side_q) begin
              if (bi_q == LAST) begin
                bph_d = BND_BOT;
                bi_d  = '0;
              end else begin
                bi_d = bi_q + 1'b1;
              end
            end
          end
          default: begin
            bi_d = bi_q + 1'b1;
          end
        endcase
        if (bnd_last) begin
          // boundary pass finished: swap grids after a step, then step again or stop
          if (in_step_q) begin
            cur_d   = !cur_q;
            steps_d = steps_q - 1'b1;
          end
          if ((in_step_q && steps_q == 16'd1) || (!in_step_q && steps_q == 16'd0)) begin
            state_d = ST_DONE;
          end else begin
            state_d = ST_CELL;
            r_d     = CW'(1);
            c_d     = CW'(1);
            ph_d    = '0;
          end
        end
      end
      ST_CELL: begin
        rd_bank = cur_q;
        ph_d    = ph_q + 1'b1;
        case (ph_q)
          4'd0:    ra = cell_addr(r9, c9);
          4'd1:    ra = cell_addr(r9, c9 - 9'd1);
          4'd2:    ra = cell_addr(r9, c9 + 9'd1);
          4'd3:    ra = cell_addr(r9 - 9'd1, c9);
          4'd4:    ra = cell_addr(r9 + 9'd1, c9);
          default: ra = cell_addr(r9, c9);
        endcase
        if (ph_q == 4'd8) begin
          we    = 1'b1;
          wbank = !cur_q;
          wa    = cell_addr(r9, c9);
          wd    = sat_v(sum);
          ph_d  = '0;
          if (c_q == PENUL) begin
            c_d = CW'(1);
            if (r_q == PENUL) begin
              state_d   = ST_BRD;
              bank_b_d  = !cur_q;
              in_step_d = 1'b1;
              bph_d     = BND_TOP;
              bi_d      = '0;
              side_d    = 1'b0;
            end else begin
              r_d = r_q + 1'b1;
            end
          end else begin
            c_d = c_q + 1'b1;
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we && !wbank) begin
      mem0[wa] <= wd;
    end
    rd0_q <= mem0[ra];
  end

  always_ff @(posedge clk_i) begin
    if (we && wbank) begin
      mem1[wa] <= wd;
    end
    rd1_q <= mem1[ra];
  end

  // stencil datapath: capture neighbors, differences, products
  always_ff @(posedge clk_i) begin
    if (state_q == ST_CELL) begin
      case (ph_q)
        4'd1: mid_q   <= rdata;
        4'd2: west_q  <= rdata;
        4'd3: east_q  <= rdata;
        4'd4: north_q <= rdata;
        4'd5: south_q <= rdata;
        4'd6: begin
          dx_q <= DW'(east_q) - (DW'(mid_q) <<< 1) + DW'(west_q);
          dy_q <= DW'(south_q) - (DW'(mid_q) <<< 1) + DW'(north_q);
        end
        4'd7: begin
          px_q <= PW'(dx_q) * PW'($signed({1'b0, coeff_x_q}));
          py_q <= PW'(dy_q) * PW'($signed({1'b0, coeff_y_q}));
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coeff_x_q   <= 16'd16384;
      coeff_y_q   <= 16'd16384;
      mode_q      <= MODE_PERIODIC;
      edge_q      <= 32'sd3276800;
      steps_cfg_q <= 16'd1000;
      state_q     <= ST_IDLE;
      cur_q       <= 1'b0;
      bank_b_q    <= 1'b0;
      in_step_q   <= 1'b0;
      steps_q     <= '0;
      bph_q       <= BND_TOP;
      bi_q        <= '0;
      side_q      <= 1'b0;
      r_q         <= '0;
      c_q         <= '0;
      ph_q        <= '0;
      rd_bank_q   <= 1'b0;
      rd_pend_q   <= 1'b0;
      rd_zero_q   <= 1'b0;
      out_valid_q <= 1'b0;
      out_done_q  <= 1'b0;
      out_val_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_COEFF_X:   coeff_x_q   <= cfg_data_i[15:0];
          REG_COEFF_Y:   coeff_y_q   <= cfg_data_i[15:0];
          REG_BND_MODE:  mode_q      <= cfg_data_i[1:0];
          REG_EDGE_TEMP: edge_q      <= cfg_data_i;
          REG_STEPS:     steps_cfg_q <= cfg_data_i[15:0];
          default: begin
          end
        endcase
      end
      state_q   <= state_d;
      cur_q     <= cur_d;
      bank_b_q  <= bank_b_d;
      in_step_q <= in_step_d;
      steps_q   <= steps_d;
      bph_q     <= bph_d;
      bi_q      <= bi_d;
      side_q    <= side_d;
      r_q       <= r_d;
      c_q       <= c_d;
      ph_q      <= ph_d;
      rd_bank_q <= rd_bank;
      rd_pend_q <= accept && (action_i == ACT_READ);
      rd_zero_q <= !in_range;
      // output register: read data is loaded in the cycle after the item is taken, run result at the end
      if (rd_pend_q) begin
        out_valid_q <= 1'b1;
        out_done_q  <= 1'b0;
        out_val_q   <= rd_zero_q ? 32'd0 : sat_r(WW'(rdata));
      end else if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
        out_done_q  <= 1'b1;
        out_val_q   <= 32'd0;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_value_o = out_val_q;
  assign run_done_o   = out_done_q;

endmodule

/* dv/tb_heat_diffusion_stencil_2d.sv */
// testbench for heat_diffusion_stencil_2d: own ftcs predictor, directed table, random phases
// depends on hds2d_pkg and the heat_diffusion_stencil_2d rtl
`timescale 1ns / 1ps

module tb_heat_diffusion_stencil_2d;
  import hds2d_pkg::*;

  localparam int SIDE      = 64;
  localparam int CELLS     = SIDE * SIDE;
  localparam int IDLE_LIMIT = 400000;

  typedef struct {
    logic signed [31:0] value;
    logic               done;
  } cell_result_t;

  typedef struct {
    logic [1:0]         act;
    logic [5:0]         row;
    logic [5:0]         col;
    logic signed [31:0] val;
    bit                 typed;
    logic signed [31:0] typed_val;
  } stim_row_t;

  logic               clk_i, rst_ni;
  logic               in_valid_i, in_stall_o;
  logic [1:0]         action_i;
  logic [5:0]         row_i, col_i;
  logic signed [31:0] cell_value_i;
  logic               out_valid_o, out_stall_i;
  logic signed [31:0] read_value_o;
  logic               run_done_o;
  logic               cfg_we_i;
  logic [2:0]         cfg_index_i;
  logic [31:0]        cfg_data_i;

  heat_diffusion_stencil_2d uut (.*);

  // predictor state
  longint     heat_grid [CELLS];
  longint     heat_next [CELLS];
  longint     diff_cx, diff_cy, edge_temp;
  logic [1:0] bnd_mode;
  int         step_total;

  cell_result_t pending_results[$];
  stim_row_t    stim_table[$];
  int  mismatch_count;
  int  idle_cycles;
  bit  hold_armed;
  int  burst_left;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  task automatic note_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // round(d*c/65536), ties toward plus infinity
  function automatic longint scale_q16(input longint d, input longint c);
    longint lowp, highp, frac;
    lowp  = d & 64'hFFFF;
    highp = (d - lowp) / 65536;
    frac  = (lowp * c + 32768) >>> 16;
    return highp * c + frac;
  endfunction

  task automatic fill_border(ref longint g[CELLS]);
    if (bnd_mode == MODE_OPEN) begin
      for (int i = 0; i < SIDE; i++) g[i] = g[SIDE + i];
      for (int j = 0; j < SIDE; j++) begin
        g[SIDE*j] = g[SIDE*j + 1];
        g[SIDE*j + SIDE-1] = g[SIDE*j + SIDE-2];
      end
      for (int i = 0; i < SIDE; i++) g[SIDE*(SIDE-1) + i] = g[SIDE*(SIDE-2) + i];
    end else if (bnd_mode == MODE_PERIODIC) begin
      for (int i = 0; i < SIDE; i++) g[i] = g[SIDE*(SIDE-2) + i];
      for (int j = 0; j < SIDE; j++) begin
        g[SIDE*j] = g[SIDE*j + SIDE-2];
        g[SIDE*j + SIDE-1] = g[SIDE*j + 1];
      end
      for (int i = 0; i < SIDE; i++) g[SIDE*(SIDE-1) + i] = g[SIDE + i];
    end else begin
      // fixed, and the unused fourth mode code
      for (int i = 0; i < SIDE; i++) g[i] = edge_temp;
      for (int j = 0; j < SIDE; j++) begin
        g[SIDE*j] = edge_temp;
        g[SIDE*j + SIDE-1] = edge_temp;
      end
      for (int i = 0; i < SIDE; i++) g[SIDE*(SIDE-1) + i] = edge_temp;
    end
  endtask

  task automatic advance_step();
    int k;
    longint mid, dx, dy;
    for (int r = 1; r < SIDE-1; r++)
      for (int c = 1; c < SIDE-1; c++) begin
        k   = r*SIDE + c;
        mid = heat_grid[k];
        dx  = heat_grid[k+1] - 2*mid + heat_grid[k-1];
        dy  = heat_grid[k+SIDE] - 2*mid + heat_grid[k-SIDE];
        heat_next[k] = clamp32(mid + scale_q16(dx, diff_cx) + scale_q16(dy, diff_cy));
      end
    fill_border(heat_next);
    heat_grid = heat_next;
  endtask

  // applies one accepted item; returns 1 and the result when one is due
  task automatic model_item(input logic [1:0] act, input logic [5:0] row,
                            input logic [5:0] col, input logic signed [31:0] val,
                            output bit has_res, output cell_result_t res);
    int idx;
    idx = row * SIDE + col;
    has_res = 1'b0;
    res.value = '0;
    res.done  = 1'b0;
    case (act)
      ACT_WRITE: heat_grid[idx] = longint'(val);
      ACT_READ: begin
        has_res = 1'b1;
        res.value = heat_grid[idx][31:0];
      end
      ACT_RUN: begin
        has_res = 1'b1;
        res.done = 1'b1;
        fill_border(heat_grid);
        for (int s = 0; s < step_total; s++) advance_step();
      end
      default: ;
    endcase
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_COEFF_X:   diff_cx = data[15:0];
      REG_COEFF_Y:   diff_cy = data[15:0];
      REG_BND_MODE:  bnd_mode = data[1:0];
      REG_EDGE_TEMP: edge_temp = longint'($signed(data));
      REG_STEPS:     step_total = data[15:0];
      default: ;
    endcase
  endtask

  // offers one item in bursts with random gaps, waits for acceptance
  task automatic send_item(input logic [1:0] act, input logic [5:0] row,
                           input logic [5:0] col, input logic signed [31:0] val,
                           input bit typed, input logic signed [31:0] typed_val);
    bit           has_res;
    cell_result_t res;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 2) != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i   <= 1'b1;
    action_i     <= act;
    row_i        <= row;
    col_i        <= col;
    cell_value_i <= val;
    do @(posedge clk_i); while (in_stall_o);
    model_item(act, row, col, val, has_res, res);
    if (has_res) begin
      if (typed) res.value = typed_val;
      pending_results.push_back(res);
    end
  endtask

  task automatic settle_idle();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 32'h000F_FFFF);
      3: return -$urandom_range(0, 32'h000F_FFFF);
      default: return $urandom;
    endcase
  endfunction

  task automatic random_item();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 47)
      send_item(ACT_WRITE, 6'($urandom), 6'($urandom), pick_value(), 1'b0, '0);
    else if (pick < 93)
      send_item(ACT_READ, 6'($urandom), 6'($urandom), $urandom, 1'b0, '0);
    else
      send_item(2'd3, 6'($urandom), 6'($urandom), $urandom, 1'b0, '0);
  endtask

  function automatic void add_row(input logic [1:0] act, input logic [5:0] row,
                                  input logic [5:0] col, input logic [31:0] val,
                                  input bit typed, input logic [31:0] typed_val);
    stim_row_t t;
    t.act = act; t.row = row; t.col = col; t.val = val;
    t.typed = typed; t.typed_val = typed_val;
    stim_table.push_back(t);
  endfunction

  // result checking and receiver stall pattern
  initial begin
    cell_result_t want;
    int hold_left, pat_cnt, pat_kind;
    hold_left = 0;
    pat_cnt = 0;
    pat_kind = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          note_mismatch("result with nothing expected");
        end else begin
          want = pending_results.pop_front();
          if (read_value_o !== want.value)
            note_mismatch($sformatf("read_value %h, want %h", read_value_o, want.value));
          if (run_done_o !== want.done)
            note_mismatch($sformatf("run_done %b, want %b", run_done_o, want.done));
        end
      end
      if (hold_armed && out_valid_o) begin
        hold_armed = 1'b0;
        hold_left = 300;
      end
      if (pat_cnt == 0) begin
        pat_cnt = $urandom_range(20, 90);
        pat_kind = $urandom_range(0, 2);
      end
      pat_cnt--;
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (pat_kind == 0)
        out_stall_i <= 1'b0;
      else if (pat_kind == 1)
        out_stall_i <= ($urandom_range(0, 3) == 0);
      else
        out_stall_i <= ($urandom_range(0, 9) < 7);
    end
  end

  // watchdog on cycles with no accepted item on either side
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("heat_diffusion_stencil_2d verification failed");
        $finish;
      end
    end
  end

  initial begin
    logic [31:0] spare;
    mismatch_count = 0;
    hold_armed = 1'b0;
    burst_left = 0;
    diff_cx = 16384;
    diff_cy = 16384;
    bnd_mode = MODE_PERIODIC;
    edge_temp = 3276800;
    step_total = 1000;
    for (int k = 0; k < CELLS; k++) begin
      heat_grid[k] = 0;
      heat_next[k] = 0;
    end
    in_valid_i   <= 1'b0;
    action_i     <= ACT_WRITE;
    row_i        <= '0;
    col_i        <= '0;
    cell_value_i <= '0;
    cfg_we_i     <= 1'b0;
    cfg_index_i  <= REG_COEFF_X;
    cfg_data_i   <= '0;
    @(posedge rst_ni);

    // a zero step run applies the boundary only
    cfg_write(REG_STEPS, 32'd0);
    // every cell gets a value so that no read or run touches an unwritten cell
    for (int k = 0; k < CELLS; k++)
      send_item(ACT_WRITE, 6'(k / SIDE), 6'(k % SIDE), pick_value(), 1'b0, '0);

    spare = $urandom;
    add_row(ACT_WRITE, 1, 1, 32'h7FFF_FFFF, 0, 0);
    add_row(ACT_READ, 1, 1, 0, 1, 32'h7FFF_FFFF);
    add_row(ACT_WRITE, 62, 62, 32'h8000_0000, 0, 0);
    add_row(ACT_READ, 62, 62, 0, 1, 32'h8000_0000);
    add_row(ACT_WRITE, 0, 0, 0, 0, 0);
    add_row(ACT_READ, 0, 0, 0, 1, 0);
    add_row(ACT_WRITE, 63, 63, 32'hFFFF_FFFF, 0, 0);
    add_row(ACT_READ, 63, 63, 0, 1, 32'hFFFF_FFFF);
    add_row(ACT_WRITE, 0, 63, 32'h0001_0000, 0, 0);
    add_row(ACT_READ, 0, 63, 0, 1, 32'h0001_0000);
    // unused action code must leave the cell alone
    add_row(2'd3, 5, 5, spare, 0, 0);
    add_row(ACT_READ, 5, 5, 0, 0, 0);
    add_row(ACT_READ, 63, 0, 0, 0, 0);
    add_row(ACT_RUN, 0, 0, 0, 1, 0);
    add_row(ACT_READ, 0, 0, 0, 0, 0);
    add_row(ACT_READ, 63, 63, 0, 0, 0);
    add_row(ACT_READ, 0, 31, 0, 0, 0);
    add_row(ACT_READ, 32, 32, 0, 0, 0);
    foreach (stim_table[i])
      send_item(stim_table[i].act, stim_table[i].row, stim_table[i].col,
                stim_table[i].val, stim_table[i].typed, stim_table[i].typed_val);
    settle_idle();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          cfg_write(REG_COEFF_X, 32'd32768);
          cfg_write(REG_COEFF_Y, 32'd0);
          cfg_write(REG_BND_MODE, 32'(MODE_FIXED));
          cfg_write(REG_EDGE_TEMP, 32'h7FFF_FFFF);
          cfg_write(REG_STEPS, 32'd1);
        end
        1: begin
          cfg_write(REG_COEFF_X, 32'd0);
          cfg_write(REG_COEFF_Y, 32'd32768);
          cfg_write(REG_BND_MODE, 32'(MODE_OPEN));
          cfg_write(REG_EDGE_TEMP, 32'h8000_0000);
          cfg_write(REG_STEPS, 32'd2);
          hold_armed = 1'b1;
        end
        2: begin
          cfg_write(REG_COEFF_X, $urandom_range(0, 32768));
          cfg_write(REG_COEFF_Y, $urandom_range(0, 32768));
          cfg_write(REG_BND_MODE, 32'(MODE_PERIODIC));
          cfg_write(REG_EDGE_TEMP, $urandom);
          cfg_write(REG_STEPS, 32'd1);
        end
        default: begin
          // largest step count is written but never run
          cfg_write(REG_STEPS, 32'd65535);
          cfg_write(REG_COEFF_X, 32'd16384);
          cfg_write(REG_COEFF_Y, 32'd16384);
          cfg_write(REG_BND_MODE, 32'd3);
          cfg_write(REG_EDGE_TEMP, $urandom);
          cfg_write(REG_STEPS, 32'd0);
        end
      endcase
      for (int n = 0; n < 140; n++) begin
        if (n == 70 || n == 139)
          send_item(ACT_RUN, 6'($urandom), 6'($urandom), $urandom, 1'b0, '0);
        else
          random_item();
      end
      settle_idle();
    end

    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("heat_diffusion_stencil_2d verification clean");
    end else begin
      $display("heat_diffusion_stencil_2d verification failed");
    end
    $finish;
  end

endmodule
